>>> src/slpd_pkg.sv
// Package of shared types and codes for the session length-prefix deframer.
`default_nettype none
package slpd_pkg;

  // Input opcodes.
  localparam logic [2:0] OP_NEW_CONN   = 3'd0;
  localparam logic [2:0] OP_CONNECTING = 3'd1;
  localparam logic [2:0] OP_CONNECTED  = 3'd2;
  localparam logic [2:0] OP_READ       = 3'd3;
  localparam logic [2:0] OP_EOS        = 3'd4;
  localparam logic [2:0] OP_ERROR      = 3'd5;

  // Result kinds.
  localparam logic [2:0] K_ACCEPT   = 3'd0;
  localparam logic [2:0] K_PAYLOAD  = 3'd1;
  localparam logic [2:0] K_EMPTY    = 3'd2;
  localparam logic [2:0] K_OVERSIZE = 3'd3;
  localparam logic [2:0] K_CLOSED   = 3'd4;
  localparam logic [2:0] K_REJECT   = 3'd5;

  // Session phases.
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_CONNECTING = 2'd1;
  localparam logic [1:0] PH_HEADER     = 2'd2;
  localparam logic [1:0] PH_DATA       = 2'd3;

  // Command classes produced by the front end.
  localparam logic [2:0] CL_OPEN_HDR  = 3'd0;
  localparam logic [2:0] CL_OPEN_CONN = 3'd1;
  localparam logic [2:0] CL_CONNECTED = 3'd2;
  localparam logic [2:0] CL_READ      = 3'd3;
  localparam logic [2:0] CL_CLOSE     = 3'd4;
  localparam logic [2:0] CL_REJECT    = 3'd5;

  localparam logic [63:0] TAG_FREE     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0]  HDR_LAST     = 3'd7;
  localparam logic [31:0] LIMIT_RESET  = 32'd67108864;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         conn_index;
    logic signed [63:0] conn_mask;
    logic [7:0]         data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         out_conn_index;
    logic signed [63:0] out_mask;
    logic [31:0]        request_id;
    logic [7:0]         payload_byte;
    logic               last_of_frame;
    logic [31:0]        frame_length;
  } out_t;

  // Classified command passed through the queue.
  typedef struct packed {
    logic [2:0]  cls;
    logic        in_range;
    logic [5:0]  idx;
    logic [63:0] mask;
    logic [7:0]  data;
  } cmd_t;

  // One session table entry.
  typedef struct packed {
    logic [1:0]  phase;
    logic [63:0] tag;
    logic [2:0]  hdr;
    logic [31:0] size;
    logic [31:0] req;
    logic [31:0] rem;
  } ent_t;

  localparam ent_t ENT_RESET = '{phase: PH_IDLE, tag: TAG_FREE, hdr: 3'd0,
                                 size: 32'd0, req: 32'd0, rem: 32'd0};

endpackage
`default_nettype wire

>>> src/slpd_front.sv
// Front end: accepts input transfers and classifies them into commands.
`default_nettype none
module slpd_front #(
  parameter int SESSIONS = 64
) (
  input  wire                 in_valid,
  output logic                in_ready,
  input  slpd_pkg::in_t       in_data,
  input  wire                 q_full,
  input  wire                 clearing,
  output logic                push,
  output slpd_pkg::cmd_t      push_cmd
);
  import slpd_pkg::*;

  logic in_range;

  // Accept whenever the queue has room and the table sweep is over.
  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;
  assign in_range = (SESSIONS > 64) ? 1'b1 : (32'(in_data.conn_index) < 32'(SESSIONS));

  // Decode the opcode into its class; an out-of-range index is rejected.
  always_comb begin
    push_cmd.in_range = in_range;
    push_cmd.idx      = in_data.conn_index;
    push_cmd.mask     = in_data.conn_mask;
    push_cmd.data     = in_data.data_byte;
    if (!in_range) begin
      push_cmd.cls = CL_REJECT;
    end else begin
      unique case (in_data.opcode)
        OP_NEW_CONN:       push_cmd.cls = CL_OPEN_HDR;
        OP_CONNECTING:     push_cmd.cls = CL_OPEN_CONN;
        OP_CONNECTED:      push_cmd.cls = CL_CONNECTED;
        OP_READ:           push_cmd.cls = CL_READ;
        OP_EOS, OP_ERROR:  push_cmd.cls = CL_CLOSE;
        default:           push_cmd.cls = CL_REJECT;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/slpd_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module slpd_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  slpd_pkg::cmd_t  push_cmd,
  input  wire             pop,
  output logic            q_valid,
  output logic            q_full,
  output slpd_pkg::cmd_t  head
);
  import slpd_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign head    = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

>>> src/slpd_back.sv
// Back end: session table read-modify-write and the result register.
`default_nettype none
module slpd_back #(
  parameter int SESSIONS = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire [31:0]      frame_limit,
  input  wire             q_valid,
  input  slpd_pkg::cmd_t  head,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  input  wire             out_ready,
  output slpd_pkg::out_t  out_data
);
  import slpd_pkg::*;

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  ent_t             mem [SESSIONS];
  ent_t             rdata;
  ent_t             byp_data;
  logic             byp;
  cmd_t             s2_cmd;
  logic             s2_valid;
  logic             s2_fire;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] s2_addr;
  logic [IDX_W-1:0] rd_addr;
  ent_t             cur;
  ent_t             nxt;
  logic             we;
  out_t             res;
  logic [31:0]      dec;

  assign s2_fire = s2_valid && (!out_valid || out_ready);
  assign pop     = q_valid && !clearing && (!s2_valid || s2_fire);
  assign s2_addr = IDX_W'(s2_cmd.idx);
  assign rd_addr = IDX_W'(head.idx);
  assign cur     = byp ? byp_data : rdata;

  // Execute one command against the session entry.
  always_comb begin
    nxt = cur;
    we  = 1'b0;
    dec = (cur.rem == 32'd0) ? 32'd0 : cur.rem - 32'd1;
    res.kind           = K_REJECT;
    res.out_conn_index = s2_cmd.idx;
    res.out_mask       = cur.tag;
    res.payload_byte   = 8'd0;
    res.last_of_frame  = 1'b0;
    case (s2_cmd.cls)
      CL_OPEN_HDR, CL_OPEN_CONN: begin
        if (cur.phase == PH_IDLE && cur.tag == TAG_FREE) begin
          nxt.phase = (s2_cmd.cls == CL_OPEN_HDR) ? PH_HEADER : PH_CONNECTING;
          nxt.tag   = s2_cmd.mask;
          nxt.hdr   = 3'd0;
          nxt.rem   = 32'd0;
          res.out_mask = s2_cmd.mask;
          res.kind  = K_ACCEPT;
        end
      end
      CL_CONNECTED: begin
        if (cur.phase == PH_CONNECTING && cur.tag == s2_cmd.mask) begin
          nxt.phase = PH_HEADER;
          nxt.hdr   = 3'd0;
          res.kind  = K_ACCEPT;
        end
      end
      CL_READ: begin
        if (cur.tag == s2_cmd.mask && cur.phase == PH_HEADER) begin
          if (!cur.hdr[2]) nxt.size = {cur.size[23:0], s2_cmd.data};
          else             nxt.req  = {cur.req[23:0], s2_cmd.data};
          if (cur.hdr != HDR_LAST) begin
            nxt.hdr  = cur.hdr + 3'd1;
            res.kind = K_ACCEPT;
          end else begin
            nxt.hdr = 3'd0;
            if (nxt.size > frame_limit) begin
              nxt.phase = PH_IDLE;
              nxt.tag   = TAG_FREE;
              nxt.rem   = 32'd0;
              res.kind  = K_OVERSIZE;
            end else if (nxt.size == 32'd0) begin
              res.kind = K_EMPTY;
            end else begin
              nxt.phase = PH_DATA;
              nxt.rem   = nxt.size;
              res.kind  = K_ACCEPT;
            end
          end
        end else if (cur.tag == s2_cmd.mask && cur.phase == PH_DATA) begin
          nxt.rem          = dec;
          res.payload_byte = s2_cmd.data;
          res.kind         = K_PAYLOAD;
          if (dec == 32'd0) begin
            res.last_of_frame = 1'b1;
            nxt.phase         = PH_HEADER;
            nxt.hdr           = 3'd0;
          end
        end
      end
      CL_CLOSE: begin
        if (cur.tag == s2_cmd.mask) begin
          nxt.phase = PH_IDLE;
          nxt.tag   = TAG_FREE;
          nxt.hdr   = 3'd0;
          nxt.rem   = 32'd0;
          res.kind  = K_CLOSED;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.request_id   = nxt.req;
    res.frame_length = nxt.size;
    if (!s2_cmd.in_range) begin
      res.out_mask     = 64'd0;
      res.request_id   = 32'd0;
      res.frame_length = 32'd0;
    end
    we = s2_cmd.in_range && (res.kind != K_REJECT);
  end

  // Session table: clearing sweep after reset, then a write per non-reject result.
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= ENT_RESET;
    else if (s2_fire && we) mem[s2_addr] <= nxt;
    if (pop) rdata <= mem[rd_addr];
  end

  // Sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(SESSIONS - 1)) clearing <= 1'b0;
    end
  end

  // Forward the entry being written when the next command hits the same session.
  always_ff @(posedge clk) begin
    if (pop) begin
      byp_data <= nxt;
      byp      <= s2_fire && we && (s2_addr == rd_addr);
      s2_cmd   <= head;
    end
  end

  // Execute stage and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop)          s2_valid <= 1'b1;
      else if (s2_fire) s2_valid <= 1'b0;
      if (s2_fire)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) out_data <= res;
  end

endmodule
`default_nettype wire

>>> src/session_length_prefix_deframer.sv
// Top level of the session length-prefix deframer.
// Takes one event or received byte per cycle while neither the result output
// nor the reset sweep holds it back, and gives exactly one result per item;
// each item passes through a queue slot, the session table read and the result
// register, and items for the same session may follow each other in consecutive
// cycles. The rate is set by the single read-modify-write of the session table
// per cycle. After reset the table is swept to its reset contents, during which
// in_ready stays low; the limit register may be written at any time it is idle.
`default_nettype none
module session_length_prefix_deframer #(
  parameter int SESSIONS = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  slpd_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output slpd_pkg::out_t  out_data,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [31:0]      cfg_data
);
  import slpd_pkg::*;

  logic        q_full;
  logic        q_valid;
  logic        push;
  logic        pop;
  logic        clearing;
  cmd_t        push_cmd;
  cmd_t        head;
  logic [31:0] frame_limit;

  // Frame size limit register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      frame_limit <= cfg_data;
    end
  end

  slpd_front #(.SESSIONS(SESSIONS)) u_front (
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_full(q_full), .clearing(clearing),
    .push(push), .push_cmd(push_cmd)
  );

  slpd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .pop(pop),
    .q_valid(q_valid), .q_full(q_full), .head(head)
  );

  slpd_back #(.SESSIONS(SESSIONS)) u_back (
    .clk(clk), .rst(rst), .frame_limit(frame_limit), .q_valid(q_valid),
    .head(head), .pop(pop), .clearing(clearing), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

>>> src/slpd_checker.sv
// Port-level checks for the session length-prefix deframer, with its bind.
`default_nettype none
module slpd_checker (
  input wire            clk,
  input wire            rst,
  input wire            out_valid,
  input wire            out_ready,
  input slpd_pkg::out_t out_data
);
  import slpd_pkg::*;

  // A stalled result transfer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a payload byte can end a frame.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_of_frame |-> out_data.kind == K_PAYLOAD)
    else $error("last mark on a non-payload result");

  // The byte field is zero unless it carries payload.
  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != K_PAYLOAD |-> out_data.payload_byte == 8'd0)
    else $error("stray payload byte");

  // An oversize close always reports a non-zero size.
  a_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == K_OVERSIZE |-> out_data.frame_length != 32'd0)
    else $error("oversize close with zero size");

  // No result straight after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind session_length_prefix_deframer slpd_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
`default_nettype wire

>>> tb/tb_session_length_prefix_deframer.sv
// Self-checking testbench for the session length-prefix deframer.
`timescale 1ns / 100ps
`default_nettype none
module tb_session_length_prefix_deframer;
  import slpd_pkg::*;

  localparam int NSESS = 64;

  // Predicts deframer results and holds them until the block delivers them.
  class deframe_scoreboard;
    logic [1:0]  phase [NSESS];
    logic [63:0] tag   [NSESS];
    logic [2:0]  hdr   [NSESS];
    logic [31:0] size  [NSESS];
    logic [31:0] req   [NSESS];
    logic [31:0] rem   [NSESS];
    logic [31:0] limit;
    out_t        pending [$];
    int          errors;
    int          matched;
    int          kind_seen [6];

    function new();
      limit = LIMIT_RESET;
      errors = 0;
      matched = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      for (int s = 0; s < NSESS; s++) begin
        phase[s] = PH_IDLE;
        tag[s] = TAG_FREE;
        hdr[s] = '0;
        size[s] = '0;
        req[s] = '0;
        rem[s] = '0;
      end
    endfunction

    function void end_session(int s);
      phase[s] = PH_IDLE;
      tag[s] = TAG_FREE;
      hdr[s] = '0;
      rem[s] = '0;
    endfunction

    // Work out the result of one accepted input transfer and update the table.
    function void note_input(in_t it);
      out_t r;
      int s;
      logic [63:0] tag_out;
      logic [31:0] left;
      s = int'(it.conn_index);
      r = '0;
      r.kind = K_REJECT;
      r.out_conn_index = it.conn_index;
      tag_out = tag[s];
      case (it.opcode)
        OP_NEW_CONN, OP_CONNECTING: begin
          if (phase[s] == PH_IDLE && tag[s] == TAG_FREE) begin
            phase[s] = (it.opcode == OP_NEW_CONN) ? PH_HEADER : PH_CONNECTING;
            tag[s] = it.conn_mask;
            hdr[s] = '0;
            rem[s] = '0;
            tag_out = it.conn_mask;
            r.kind = K_ACCEPT;
          end
        end
        OP_CONNECTED: begin
          if (phase[s] == PH_CONNECTING && tag[s] == it.conn_mask) begin
            phase[s] = PH_HEADER;
            hdr[s] = '0;
            r.kind = K_ACCEPT;
          end
        end
        OP_READ: begin
          if (tag[s] == it.conn_mask && phase[s] == PH_HEADER) begin
            if (hdr[s] < 4) size[s] = {size[s][23:0], it.data_byte};
            else req[s] = {req[s][23:0], it.data_byte};
            if (hdr[s] != HDR_LAST) begin
              hdr[s] = hdr[s] + 3'd1;
              r.kind = K_ACCEPT;
            end else begin
              hdr[s] = '0;
              if (size[s] > limit) begin
                end_session(s);
                r.kind = K_OVERSIZE;
              end else if (size[s] == 0) begin
                r.kind = K_EMPTY;
              end else begin
                phase[s] = PH_DATA;
                rem[s] = size[s];
                r.kind = K_ACCEPT;
              end
            end
          end else if (tag[s] == it.conn_mask && phase[s] == PH_DATA) begin
            left = (rem[s] == 0) ? 32'd0 : rem[s] - 32'd1;
            rem[s] = left;
            r.payload_byte = it.data_byte;
            if (left == 0) begin
              r.last_of_frame = 1'b1;
              phase[s] = PH_HEADER;
              hdr[s] = '0;
            end
            r.kind = K_PAYLOAD;
          end
        end
        OP_EOS, OP_ERROR: begin
          if (tag[s] == it.conn_mask) begin
            end_session(s);
            r.kind = K_CLOSED;
          end
        end
        default: ;
      endcase
      r.out_mask = tag_out;
      r.request_id = req[s];
      r.frame_length = size[s];
      pending.push_back(r);
    endfunction

    // Compare one delivered result with the oldest prediction.
    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (want.kind < 6) kind_seen[want.kind]++;
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.out_conn_index !== want.out_conn_index) begin
        $display("%0t: index expected %0d actual %0d", $time, want.out_conn_index,
                 got.out_conn_index);
        errors++;
      end
      if (got.out_mask !== want.out_mask) begin
        $display("%0t: mask expected %h actual %h", $time, want.out_mask, got.out_mask);
        errors++;
      end
      if (got.request_id !== want.request_id) begin
        $display("%0t: request id expected %h actual %h", $time, want.request_id,
                 got.request_id);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload expected %h actual %h", $time, want.payload_byte,
                 got.payload_byte);
        errors++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $display("%0t: last expected %b actual %b", $time, want.last_of_frame,
                 got.last_of_frame);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $display("%0t: length expected %h actual %h", $time, want.frame_length,
                 got.frame_length);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  deframe_scoreboard sb = new();
  bit quiet = 1'b0;   // no idling in the last part of the run
  int items_sent = 0;

  session_length_prefix_deframer #(.SESSIONS(NSESS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall bursts, and every delivered transfer is checked.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Send one input transfer, with an occasional idle burst beforehand.
  // Valid stays high after the transfer until the next caller changes it.
  task automatic send_item(input logic [2:0] op, input logic [5:0] idx,
                           input logic [63:0] mask, input logic [7:0] b);
    in_t it;
    int gap;
    it.opcode = op;
    it.conn_index = idx;
    it.conn_mask = mask;
    it.data_byte = b;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  // Write the frame limit once every prediction has been delivered.
  task automatic write_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.limit = value;
  endtask

  // A header of eight bytes: size then request id, both big-endian.
  task automatic send_header(input logic [5:0] idx, input logic [63:0] mask,
                             input logic [31:0] len, input logic [31:0] rid);
    logic [63:0] h;
    h = {len, rid};
    for (int i = 7; i >= 0; i--) send_item(OP_READ, idx, mask, h[i*8 +: 8]);
  endtask

  // A well-formed session with random frames, usually closed at the end.
  task automatic run_session(input logic [5:0] idx);
    logic [63:0] mask;
    int frames;
    int len;
    mask = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      send_item(OP_NEW_CONN, idx, mask, 8'($urandom));
    end else begin
      send_item(OP_CONNECTING, idx, mask, 8'($urandom));
      send_item(OP_CONNECTED, idx, mask, 8'($urandom));
    end
    frames = $urandom_range(1, 3);
    repeat (frames) begin
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) len = int'(sb.limit + 32'd1);
      send_header(idx, mask, 32'(len), $urandom);
      if (len > 12) break;
      repeat (len) begin
        if ($urandom_range(0, 15) == 0)
          send_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, NSESS - 1)),
                    {$urandom, $urandom}, 8'($urandom));
        send_item(OP_READ, idx, mask, 8'($urandom));
      end
    end
    if ($urandom_range(0, 3) != 0)
      send_item($urandom_range(0, 1) ? OP_EOS : OP_ERROR, idx, mask, 8'($urandom));
  endtask

  // Stimulus: directed cases first, then random sessions under several limits.
  initial begin
    logic [63:0] m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Opening, refusing a busy open, data, empty frame and a bad tag.
    m = 64'h8000_0000_0000_0000;
    send_item(OP_NEW_CONN, 6'd0, m, 8'h00);
    send_item(OP_CONNECTING, 6'd0, m, 8'hFF);
    send_header(6'd0, m, 32'd1, 32'hFFFF_FFFF);
    send_item(OP_READ, 6'd0, m, 8'hFF);
    send_header(6'd0, m, 32'd0, 32'h1234_5678);
    send_item(OP_READ, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF, 8'h55);
    send_item(OP_EOS, 6'd0, m, 8'h00);
    // Out-of-order connected, read before connected, unknown opcodes.
    send_item(OP_CONNECTED, 6'd63, 64'd0, 8'h00);
    send_item(OP_CONNECTING, 6'd63, 64'd0, 8'h00);
    send_item(OP_READ, 6'd63, 64'd0, 8'hAA);
    send_item(3'd6, 6'd63, 64'd0, 8'h00);
    send_item(3'd7, 6'd63, 64'd0, 8'h00);
    send_item(OP_CONNECTED, 6'd63, 64'd0, 8'h00);
    send_item(OP_ERROR, 6'd63, 64'd0, 8'h00);
    // A zero limit closes any non-empty frame as oversize.
    write_limit(32'd0);
    send_item(OP_NEW_CONN, 6'd5, 64'd1, 8'h00);
    send_header(6'd5, 64'd1, 32'd1, 32'd9);
    write_limit(32'hFFFF_FFFF);

    // Random sessions with interleaved noise.
    while (items_sent < 1200) begin
      if (items_sent > 400 && items_sent < 430) write_limit($urandom_range(0, 12));
      if (items_sent > 800 && items_sent < 830) write_limit(LIMIT_RESET);
      if (items_sent > 1000) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0)
        send_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, NSESS - 1)),
                  ($urandom_range(0, 1) ? TAG_FREE : {$urandom, $urandom}),
                  8'($urandom));
      else
        run_session(6'($urandom_range(0, 7)));
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d input transfers and %0d checked results.", items_sent, sb.matched);
    $display("Kinds: accept %0d, payload %0d, empty %0d, oversize %0d, closed %0d, reject %0d.",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4], sb.kind_seen[5]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_session_length_prefix_deframer passed");
    end else begin
      $display("tb_session_length_prefix_deframer failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("tb_session_length_prefix_deframer failed");
    $finish;
  end
endmodule
`default_nettype wire
